// File: sv/obs_pcm_pkg.sv
// ----------------------------------------------------------------------------
// obs_pcm_pkg
// shared types and constants for the one-bit speaker to pcm unit
// ----------------------------------------------------------------------------
package obs_pcm_pkg;

    localparam int RATE_W   = 18;
    localparam int FREQ_W   = 24;
    localparam int AMP_W    = 15;
    localparam int CAP_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [RATE_W-1:0] RESET_SAMPLE_RATE   = RATE_W'(44100);
    localparam logic [FREQ_W-1:0] RESET_CPU_FREQUENCY = FREQ_W'(1023000);
    localparam logic [AMP_W-1:0]  RESET_AMPLITUDE     = AMP_W'(8000);
    localparam logic [CAP_W-1:0]  RESET_FRAME_CAP     = CAP_W'(8192);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE   = 2'd0,
        CFG_CPU_FREQUENCY = 2'd1,
        CFG_AMPLITUDE     = 2'd2,
        CFG_FRAME_CAP     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0] sample_rate;
        logic [FREQ_W-1:0] cpu_frequency;
        logic [AMP_W-1:0]  amplitude;
        logic [CAP_W-1:0]  frame_sample_cap;
    } t_cfg;

    typedef struct packed {
        logic                       produce;
        logic                       has_sample;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_frame;
    } t_result;

endpackage

// File: sv/obs_pcm_cfg.sv
// ----------------------------------------------------------------------------
// obs_pcm_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module obs_pcm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [obs_pcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [obs_pcm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output obs_pcm_pkg::t_cfg                   o_cfg
);

    obs_pcm_pkg::t_cfg r_cfg;
    obs_pcm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (obs_pcm_pkg::t_cfg_idx'(i_cfg_index))
                obs_pcm_pkg::CFG_SAMPLE_RATE:
                    n_cfg.sample_rate = i_cfg_wdata[obs_pcm_pkg::RATE_W-1:0];
                obs_pcm_pkg::CFG_CPU_FREQUENCY:
                    n_cfg.cpu_frequency = i_cfg_wdata[obs_pcm_pkg::FREQ_W-1:0];
                obs_pcm_pkg::CFG_AMPLITUDE:
                    n_cfg.amplitude = i_cfg_wdata[obs_pcm_pkg::AMP_W-1:0];
                obs_pcm_pkg::CFG_FRAME_CAP:
                    n_cfg.frame_sample_cap = i_cfg_wdata[obs_pcm_pkg::CAP_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate      <= obs_pcm_pkg::RESET_SAMPLE_RATE;
            r_cfg.cpu_frequency    <= obs_pcm_pkg::RESET_CPU_FREQUENCY;
            r_cfg.amplitude        <= obs_pcm_pkg::RESET_AMPLITUDE;
            r_cfg.frame_sample_cap <= obs_pcm_pkg::RESET_FRAME_CAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/obs_pcm_core.sv
// ----------------------------------------------------------------------------
// obs_pcm_core
// phase accumulator, per-frame sample counter and speaker level
// ----------------------------------------------------------------------------
module obs_pcm_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_toggle,
    input  logic                 i_frame_end,
    input  obs_pcm_pkg::t_cfg    i_cfg,
    output obs_pcm_pkg::t_result o_result
);

    localparam int FW = obs_pcm_pkg::FREQ_W;

    logic                            r_level;
    logic [FW-1:0]                   r_phase;
    logic [obs_pcm_pkg::CAP_W-1:0]   r_count;

    logic                            n_level;
    logic [FW-1:0]                   n_phase;
    logic [obs_pcm_pkg::CAP_W-1:0]   n_count;

    logic [FW-1:0]                   freq;
    logic [FW:0]                     sum;
    logic [FW:0]                     diff;
    logic                            tick;
    logic                            emit;
    logic [obs_pcm_pkg::SAMPLE_W-1:0] amp_ext;

    always_comb begin
        // zero frequency behaves as one
        freq    = (i_cfg.cpu_frequency == '0) ? FW'(1) : i_cfg.cpu_frequency;
        sum     = {1'b0, r_phase} + (FW+1)'(i_cfg.sample_rate);
        tick    = (sum >= {1'b0, freq});
        diff    = sum - {1'b0, freq};
        emit    = tick && (r_count < i_cfg.frame_sample_cap);
        amp_ext = obs_pcm_pkg::SAMPLE_W'(i_cfg.amplitude);

        if (!tick) begin
            n_phase = sum[FW-1:0];
        end else if (diff >= {1'b0, freq}) begin
            // remainder still not below frequency: saturate one short of the wrap
            n_phase = freq - FW'(1);
        end else begin
            n_phase = diff[FW-1:0];
        end
        n_count = emit ? r_count + obs_pcm_pkg::CAP_W'(1) : r_count;
        if (i_frame_end) begin
            n_phase = '0;
            n_count = '0;
        end
        n_level = r_level ^ i_toggle;

        o_result.produce       = emit || i_frame_end;
        o_result.has_sample    = emit;
        o_result.last_of_frame = i_frame_end;
        if (!emit) begin
            o_result.sample = '0;
        end else if (r_level) begin
            o_result.sample = $signed(amp_ext);
        end else begin
            o_result.sample = $signed(obs_pcm_pkg::SAMPLE_W'(0) - amp_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_phase <= '0;
            r_count <= '0;
        end else if (i_advance) begin
            r_level <= n_level;
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_frame_end |=> r_phase == '0 && r_count == '0)
        else $error("frame end did not clear phase and count");

    a_toggle_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_toggle |=> r_level != $past(r_level))
        else $error("toggle did not flip speaker level");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_frame_end && !o_result.has_sample |=> $stable(r_count))
        else $error("sample count moved without a sample");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_phase) && $stable(r_level))
        else $error("state moved without an item");

endmodule

// File: sv/one_bit_speaker_to_pcm_unit.sv
// ----------------------------------------------------------------------------
// one_bit_speaker_to_pcm_unit
// resamples a one-bit speaker level, one request per cpu tick, into pcm
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  ------    ---------------------  ----------------------------------------
//  in        i_valid / o_ready      i_toggle, i_frame_end
//  out       o_valid / i_ready      o_has_sample, o_sample, o_last_of_frame
//  config    i_cfg_we (no wait)     i_cfg_index, i_cfg_wdata
//
//  one request per cycle sustained while the result slot is free; input
//  register feeds the phase update, result register holds the output
//  the phase/count/level loop closes with one add, one subtract and
//  two compares on the phase, one compare and one increment on the count
//  reset (synchronous, active low) clears state and both valids, presets config
//  a stalled result blocks the input register only; ticks with no sample
//  and no frame end leave no result but still wait for a free output slot
// ----------------------------------------------------------------------------
module one_bit_speaker_to_pcm_unit (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // input requests
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic                                       i_toggle,
    input  logic                                       i_frame_end,
    // result requests
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic                                       o_has_sample,
    output logic signed [obs_pcm_pkg::SAMPLE_W-1:0]    o_sample,
    output logic                                       o_last_of_frame,
    // configuration
    input  logic                                       i_cfg_we,
    input  logic [obs_pcm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [obs_pcm_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);

    obs_pcm_pkg::t_cfg    cfg;
    obs_pcm_pkg::t_result core_result;

    // input register
    logic r_in_valid;
    logic r_in_toggle;
    logic r_in_frame_end;

    // result register
    logic                 r_out_valid;
    obs_pcm_pkg::t_result r_out;

    logic out_free;
    logic advance;
    logic in_take;

    // the result slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_ready;
    // the held request moves through the core only with room for its result
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign in_take  = i_valid && o_ready;

    obs_pcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    obs_pcm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_toggle    (r_in_toggle),
        .i_frame_end (r_in_frame_end),
        .i_cfg       (cfg),
        .o_result    (core_result)
    );

    // input register: loads whenever a request is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_toggle    <= i_toggle;
            r_in_frame_end <= i_frame_end;
        end
    end

    // result register: filled only by ticks that produce a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && core_result.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_result.produce) begin
            r_out <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_has_sample    = r_out.has_sample;
    assign o_sample        = r_out.sample;
    assign o_last_of_frame = r_out.last_of_frame;

    a_result_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.has_sample || r_out.last_of_frame)
        else $error("result carries neither sample nor frame end");

    a_empty_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.has_sample |-> r_out.sample == '0)
        else $error("non-zero sample without sample flag");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid && $stable(r_in_toggle)
            && $stable(r_in_frame_end))
        else $error("held request lost during result stall");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the one-bit speaker to pcm unit: an internal phase
// and level predictor follows every accepted tick request, and each pcm
// request leaving the unit is compared with the oldest predicted word
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 5;
    localparam int PIPE_SETTLE  = 4;      // two-stage pipe plus margin
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int LONG_STALL   = 80;
    localparam int PHASES       = 10;
    localparam int PHASE_TICKS  = 125;

    typedef struct {
        bit                                      has_sample;
        logic signed [obs_pcm_pkg::SAMPLE_W-1:0] sample;
        bit                                      last_of_frame;
    } t_pcm_word;

    // predictor of the resampler plus the store of words still owed by the unit
    class t_pcm_predictor;
        logic [obs_pcm_pkg::RATE_W-1:0]  rate;
        logic [obs_pcm_pkg::FREQ_W-1:0]  freq;
        logic [obs_pcm_pkg::AMP_W-1:0]   amp;
        logic [obs_pcm_pkg::CAP_W-1:0]   cap;
        bit                              level;
        logic [obs_pcm_pkg::FREQ_W-1:0]  phase;
        logic [obs_pcm_pkg::CAP_W-1:0]   count;
        t_pcm_word                       owed_words[$];
        int                              mismatches;

        function new();
            rate       = obs_pcm_pkg::RESET_SAMPLE_RATE;
            freq       = obs_pcm_pkg::RESET_CPU_FREQUENCY;
            amp        = obs_pcm_pkg::RESET_AMPLITUDE;
            cap        = obs_pcm_pkg::RESET_FRAME_CAP;
            level      = 1'b0;
            phase      = '0;
            count      = '0;
            mismatches = 0;
        endfunction

        function void set_reg(obs_pcm_pkg::t_cfg_idx idx,
                              logic [obs_pcm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                obs_pcm_pkg::CFG_SAMPLE_RATE:   rate = data[obs_pcm_pkg::RATE_W-1:0];
                obs_pcm_pkg::CFG_CPU_FREQUENCY: freq = data[obs_pcm_pkg::FREQ_W-1:0];
                obs_pcm_pkg::CFG_AMPLITUDE:     amp  = data[obs_pcm_pkg::AMP_W-1:0];
                obs_pcm_pkg::CFG_FRAME_CAP:     cap  = data[obs_pcm_pkg::CAP_W-1:0];
                default: ;
            endcase
        endfunction

        function int owed();
            return owed_words.size();
        endfunction

        // advance the phase for one tick request and queue any word it causes
        function void note_tick(bit toggle, bit frame_end);
            logic [obs_pcm_pkg::FREQ_W:0]   nxt;
            logic [obs_pcm_pkg::FREQ_W-1:0] wrap;
            bit                             wrapped;
            t_pcm_word                      w;
            wrap    = (freq == '0) ? obs_pcm_pkg::FREQ_W'(1) : freq;
            nxt     = {1'b0, phase} + (obs_pcm_pkg::FREQ_W + 1)'(rate);
            wrapped = 1'b0;
            w.has_sample    = 1'b0;
            w.sample        = '0;
            w.last_of_frame = frame_end;
            if (nxt >= {1'b0, wrap}) begin
                wrapped = 1'b1;
                nxt = nxt - {1'b0, wrap};
                // remainder still at or above the wrap value: one sample per tick at most
                if (nxt >= {1'b0, wrap})
                    nxt = {1'b0, wrap} - 1'b1;
            end
            phase = nxt[obs_pcm_pkg::FREQ_W-1:0];
            if (wrapped && count < cap) begin
                w.has_sample = 1'b1;
                count = count + 1'b1;
                w.sample = level ? $signed({1'b0, amp}) : -$signed({1'b0, amp});
            end
            if (toggle)
                level = ~level;
            if (frame_end) begin
                phase = '0;
                count = '0;
            end
            if (w.has_sample || frame_end)
                owed_words.push_back(w);
        endfunction

        function void check_word(bit has_sample,
                                 logic signed [obs_pcm_pkg::SAMPLE_W-1:0] sample,
                                 bit last_of_frame);
            t_pcm_word w;
            if (owed_words.size() == 0) begin
                $display("%0t: expected no pcm word, actual has_sample=%0b sample=%0d last=%0b",
                         $time, has_sample, sample, last_of_frame);
                mismatches++;
                return;
            end
            w = owed_words.pop_front();
            if (has_sample !== w.has_sample) begin
                $display("%0t: has_sample expected %0b actual %0b",
                         $time, w.has_sample, has_sample);
                mismatches++;
            end
            if (sample !== w.sample) begin
                $display("%0t: sample expected %0d actual %0d", $time, w.sample, sample);
                mismatches++;
            end
            if (last_of_frame !== w.last_of_frame) begin
                $display("%0t: last_of_frame expected %0b actual %0b",
                         $time, w.last_of_frame, last_of_frame);
                mismatches++;
            end
        endfunction
    endclass

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n;
    logic                                    i_valid;
    logic                                    o_ready;
    logic                                    i_toggle;
    logic                                    i_frame_end;
    logic                                    o_valid;
    logic                                    i_ready;
    logic                                    o_has_sample;
    logic signed [obs_pcm_pkg::SAMPLE_W-1:0] o_sample;
    logic                                    o_last_of_frame;
    logic                                    i_cfg_we;
    logic [obs_pcm_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [obs_pcm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata;

    t_pcm_predictor model = new();

    // per-phase idling controls set by the stimulus, and the watchdog's quiet count
    bit in_calm     = 1'b0;
    bit out_calm    = 1'b0;
    bit hold_output = 1'b0;
    int quiet_cycles = 0;

    one_bit_speaker_to_pcm_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_toggle        (i_toggle),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_sample    (o_has_sample),
        .o_sample        (o_sample),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // at least half of the draws give no gap at all so back-to-back requests are common
    function automatic int draw_gap(bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // both handshakes observed at the edge: the result first, since it is older
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                model.check_word(o_has_sample, o_sample, o_last_of_frame);
            if (i_valid && o_ready)
                model.note_tick(i_toggle, i_frame_end);
        end
    end

    // watchdog on cycles where neither channel moves a request
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: a stall drawn per request, or one long hold-off on demand
    initial begin : result_sink
        int stall;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                stall = LONG_STALL;
            end else begin
                stall = draw_gap(out_calm);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // offer one tick request and return at the edge where it is taken
    task automatic offer_tick(input bit toggle, input bit frame_end);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_toggle    <= toggle;
        i_frame_end <= frame_end;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stop offering, wait for every owed word, then let silent ticks leave the pipe
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (model.owed() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input obs_pcm_pkg::t_cfg_idx idx,
                             input logic [obs_pcm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        model.set_reg(idx, data);
    endtask

    task automatic apply_cfg(input int rate, input int freq, input int amp, input int cap);
        write_reg(obs_pcm_pkg::CFG_SAMPLE_RATE,   obs_pcm_pkg::CFG_DATA_W'(rate));
        write_reg(obs_pcm_pkg::CFG_CPU_FREQUENCY, obs_pcm_pkg::CFG_DATA_W'(freq));
        write_reg(obs_pcm_pkg::CFG_AMPLITUDE,     obs_pcm_pkg::CFG_DATA_W'(amp));
        write_reg(obs_pcm_pkg::CFG_FRAME_CAP,     obs_pcm_pkg::CFG_DATA_W'(cap));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int rate;
        int freq;
        int amp;
        int cap;
        int fe_odds;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_toggle    <= 1'b0;
        i_frame_end <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= obs_pcm_pkg::CFG_SAMPLE_RATE;
        i_cfg_wdata <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: frame end with no sample, then a bare toggle
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b1, 1'b0);

        // tight ratio with a cap of two: cap reached, frame end with and
        // without a sample, full-scale amplitude
        wait_for_drain();
        apply_cfg(3, 7, 32767, 2);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b1);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b1, 1'b1);

        // zero frequency taken as one, phase saturates, zero amplitude
        wait_for_drain();
        apply_cfg(5, 0, 0, 65535);
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b0, 1'b1);

        // widest rate against a small wrap, every sample held back by a zero cap
        wait_for_drain();
        apply_cfg(262143, 3, 21845, 0);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b1, 1'b1);

        // zero rate: the phase never moves
        wait_for_drain();
        apply_cfg(0, 1, 12345, 1);
        offer_tick(1'b0, 1'b0);
        offer_tick(1'b1, 1'b0);
        offer_tick(1'b0, 1'b1);

        // random phases, each with its own settings and idling style
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_for_drain();
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            amp      = $urandom_range(0, 32767);
            case (ph)
                0: begin
                    rate = 44100; freq = 1023000; amp = 8000; cap = 8192; fe_odds = 64;
                end
                1: begin
                    freq = $urandom_range(1, 40); rate = $urandom_range(0, freq);
                    cap = $urandom_range(1, 8); fe_odds = 16;
                end
                2: begin
                    rate = 262143; freq = 16777215; amp = 32767; cap = 65535;
                    fe_odds = 256; in_calm = 1'b1; out_calm = 1'b1;
                end
                3: begin
                    // a result for every tick while the sink holds off
                    freq = $urandom_range(1, 1000); rate = freq + $urandom_range(0, 1000);
                    amp = 0; cap = 65535; fe_odds = 32; in_calm = 1'b1;
                end
                4: begin
                    rate = 1; freq = 1; cap = 65535; fe_odds = 8;
                    in_calm = 1'b1; out_calm = 1'b1;
                end
                5: begin
                    freq = $urandom_range(1, 16777215); rate = $urandom_range(0, 262143);
                    cap = $urandom_range(1, 65535); fe_odds = 4;
                end
                6: begin
                    freq = $urandom_range(2, 500); rate = $urandom_range(1, freq - 1);
                    cap = $urandom_range(1, 65535); fe_odds = 32;
                end
                7: begin
                    freq = $urandom_range(1, 50); rate = $urandom_range(0, 100);
                    cap = 0; fe_odds = 8;
                end
                8: begin
                    freq = 0; rate = $urandom_range(0, 300);
                    cap = $urandom_range(1, 40); fe_odds = 16;
                end
                default: begin
                    freq = $urandom_range(1, 64); rate = $urandom_range(0, 2 * freq);
                    cap = $urandom_range(1, 20); fe_odds = $urandom_range(1, 40);
                end
            endcase
            apply_cfg(rate, freq, amp, cap);
            if (ph == 3)
                hold_output = 1'b1;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                // mid-phase pause until every owed word is out
                if (ph == 6 && n == PHASE_TICKS / 2)
                    wait_for_drain();
                offer_tick($urandom_range(0, 1), $urandom_range(0, fe_odds - 1) == 0);
            end
        end

        wait_for_drain();
        repeat (2 * PIPE_SETTLE) @(posedge i_clk);
        if (model.mismatches == 0 && model.owed() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/obs_pcm_pkg.sv
sv/obs_pcm_cfg.sv
sv/obs_pcm_core.sv
sv/one_bit_speaker_to_pcm_unit.sv
verif/tb.sv
